// ===== rtl/two_axis_filtered_pd_servo_top_defines.svh =====
// Assertion macros shared by the servo RTL.
`ifndef TWO_AXIS_FILTERED_PD_SERVO_TOP_DEFINES_SVH
`define TWO_AXIS_FILTERED_PD_SERVO_TOP_DEFINES_SVH

`ifndef SYNTH
// Clocked check on clk_i, off while rst_ni is low.
`define TAFPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tafps assertion failed");
// Same-cycle implication.
`define TAFPS_ASSERT_IMPL(lbl, ante, cons) `TAFPS_ASSERT(lbl, (ante) |-> (cons))
`else
`define TAFPS_ASSERT(lbl, prop)
`define TAFPS_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

// ===== rtl/tafps_pkg.sv =====
`default_nettype none

package tafps_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int FRAC_BITS   = 8;
  localparam int POS_BITS    = SAMPLE_BITS + FRAC_BITS;
  localparam int ERR_W       = POS_BITS + 1;
  localparam int GAIN_W      = 16;
  localparam int GAIN_FRAC   = 8;
  localparam int DUTY_OUT_W  = 16;

  // Lowpass: Q0.16 weights, sum to one.
  localparam int COEF_FRAC   = 16;
  localparam int FILT_ACC_W  = POS_BITS + COEF_FRAC + 1;
  localparam logic [15:0] IN_WEIGHT_Q16 = 16'd20998;
  localparam logic [15:0] FB_WEIGHT_Q16 = 16'd44538;
  localparam logic [15:0] FILT_ROUND    = 16'd32768;

  // PD datapath widths.
  localparam int PROD_P_W  = GAIN_W + 1 + ERR_W;
  localparam int PROD_D_W  = GAIN_W + 1 + ERR_W + 1;
  localparam int PD_ACC_W  = PROD_D_W + 1;
  localparam int PD_SHIFT  = GAIN_FRAC + FRAC_BITS;
  localparam int PD_Q_W    = PD_ACC_W - PD_SHIFT;
  localparam int DUTY_W    = PD_Q_W + 1;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P_X     = 3'd0,
    REG_GAIN_D_X     = 3'd1,
    REG_GAIN_P_Y     = 3'd2,
    REG_GAIN_D_Y     = 3'd3,
    REG_CENTRE_DUTY_X = 3'd4,
    REG_CENTRE_DUTY_Y = 3'd5,
    REG_DUTY_MIN     = 3'd6,
    REG_DUTY_MAX     = 3'd7
  } cfg_reg_e;

  localparam logic [15:0] GAIN_P_X_RST      = 16'd31;
  localparam logic [15:0] GAIN_D_X_RST      = 16'd768;
  localparam logic [15:0] GAIN_P_Y_RST      = 16'd26;
  localparam logic [15:0] GAIN_D_Y_RST      = 16'd512;
  localparam logic [15:0] CENTRE_DUTY_X_RST = 16'd3720;
  localparam logic [15:0] CENTRE_DUTY_Y_RST = 16'd3700;
  localparam logic [15:0] DUTY_MIN_RST      = 16'd3600;
  localparam logic [15:0] DUTY_MAX_RST      = 16'd3800;

  typedef struct packed {
    logic [GAIN_W-1:0]     kp;
    logic [GAIN_W-1:0]     kd;
    logic [DUTY_OUT_W-1:0] centre;
  } pd_gains_t;

  typedef struct packed {
    logic [DUTY_OUT_W-1:0] lo;
    logic [DUTY_OUT_W-1:0] hi;
  } duty_lim_t;

  typedef struct packed {
    logic [DUTY_OUT_W-1:0] duty;
    logic                  clip;
  } pd_result_t;

endpackage

`default_nettype wire

// ===== rtl/tafps_if.sv =====
`default_nettype none

// Input channel: one beat per control period.
interface tafps_in_if import tafps_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] adc_sample;
  logic [POS_BITS-1:0]    ref_x;
  logic [POS_BITS-1:0]    ref_y;

  modport source (output valid, output adc_sample, output ref_x, output ref_y,
                  input ready);
  modport sink   (input valid, input adc_sample, input ref_x, input ref_y,
                  output ready);
endinterface

// Result channel.
interface tafps_out_if import tafps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [DUTY_OUT_W-1:0] duty_x;
  logic [DUTY_OUT_W-1:0] duty_y;
  logic                  clipped_x;
  logic                  clipped_y;
  logic                  sampled_axis;

  modport source (output valid, output duty_x, output duty_y, output clipped_x,
                  output clipped_y, output sampled_axis, input ready);
  modport sink   (input valid, input duty_x, input duty_y, input clipped_x,
                  input clipped_y, input sampled_axis, output ready);
endinterface

// Configuration write channel.
interface tafps_cfg_if import tafps_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [15:0]          data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tafps_pd_axis.sv =====
`default_nettype none

module tafps_pd_axis import tafps_pkg::*; (
  input  wire logic [POS_BITS-1:0]    ref_i,
  input  wire logic [POS_BITS-1:0]    filt_i,
  input  wire logic signed [ERR_W-1:0] prev_err_i,
  input  wire pd_gains_t              gains_i,
  input  wire duty_lim_t              lim_i,
  output logic signed [ERR_W-1:0]     err_o,
  output pd_result_t                  res_o
);

  logic signed [ERR_W:0]        diff;
  logic signed [GAIN_W:0]       kp_s;
  logic signed [GAIN_W:0]       kd_s;
  logic signed [PROD_P_W-1:0]   prod_p;
  logic signed [PROD_D_W-1:0]   prod_d;
  logic signed [PD_ACC_W-1:0]   acc;
  logic signed [PD_ACC_W-1:0]   acc_adj;
  logic signed [PD_Q_W-1:0]     corr;
  logic signed [DUTY_W-1:0]     duty_raw;
  logic signed [DUTY_W-1:0]     lo_s;
  logic signed [DUTY_W-1:0]     hi_s;
  logic signed [DUTY_W-1:0]     duty_cap;
  logic signed [DUTY_W-1:0]     duty_sat;
  logic                         clip_hi;
  logic                         clip_lo;

  always_comb begin
    err_o  = $signed({1'b0, ref_i}) - $signed({1'b0, filt_i});
    diff   = $signed({err_o[ERR_W-1], err_o}) - $signed({prev_err_i[ERR_W-1], prev_err_i});
    kp_s   = $signed({1'b0, gains_i.kp});
    kd_s   = $signed({1'b0, gains_i.kd});
    prod_p = kp_s * err_o;
    prod_d = kd_s * diff;
    acc    = PD_ACC_W'(prod_p) + PD_ACC_W'(prod_d);
    // Bias negative values so the arithmetic shift rounds toward zero.
    acc_adj = acc + (acc[PD_ACC_W-1] ? PD_ACC_W'((64'd1 << PD_SHIFT) - 64'd1)
                                     : PD_ACC_W'(0));
    corr     = $signed(acc_adj[PD_ACC_W-1:PD_SHIFT]);
    duty_raw = DUTY_W'($signed({1'b0, gains_i.centre})) - DUTY_W'(corr);
    lo_s     = DUTY_W'($signed({1'b0, lim_i.lo}));
    hi_s     = DUTY_W'($signed({1'b0, lim_i.hi}));
    // Cap at the ceiling first, then raise to the floor.
    clip_hi  = duty_raw > hi_s;
    duty_cap = clip_hi ? hi_s : duty_raw;
    clip_lo  = duty_cap < lo_s;
    duty_sat = clip_lo ? lo_s : duty_cap;
    res_o.duty = duty_sat[DUTY_OUT_W-1:0];
    res_o.clip = clip_hi | clip_lo;
  end

endmodule

`default_nettype wire

// ===== rtl/two_axis_filtered_pd_servo_top.sv =====
// Channel   Role    Beat contents
// -------   ------  ---------------------------------------------------
// sample_i  sink    adc_sample, ref_x, ref_y (one control period)
// result_o  source  duty_x, duty_y, clipped_x, clipped_y, sampled_axis
// cfg_i     sink    index, data (register write, always ready)
//
// One beat in, one beat out; a new beat is taken every cycle unless a stall on result_o has filled all stages.
// Three register stages: input, lowpass, PD result. A result is valid once
// its beat has passed the input and lowpass stages into the PD result stage.
// The lowpass stage owns filt_x/filt_y, the PD stage owns the previous errors.
// A stall on result_o backs up stage by stage; sample_i.ready drops only when
// all three stages hold a beat. Reset clears state and loads the config defaults, no sweep.
`default_nettype none
`include "two_axis_filtered_pd_servo_top_defines.svh"

module two_axis_filtered_pd_servo_top import tafps_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tafps_in_if.sink    sample_i,
  tafps_out_if.source result_o,
  tafps_cfg_if.sink   cfg_i
);

  // Config registers.
  logic [15:0] gain_p_x_q, gain_d_x_q, gain_p_y_q, gain_d_y_q;
  logic [15:0] centre_x_q, centre_y_q, duty_min_q, duty_max_q;

  // Loop state.
  logic                     axis_sel_q;
  logic [POS_BITS-1:0]      filt_x_q, filt_y_q;
  logic signed [ERR_W-1:0]  prev_err_x_q, prev_err_y_q;

  // Stage A: input register.
  logic                     a_vld_q;
  logic [SAMPLE_BITS-1:0]   a_sample_q;
  logic [POS_BITS-1:0]      a_ref_x_q, a_ref_y_q;

  // Stage B: filtered positions.
  logic                     b_vld_q;
  logic [POS_BITS-1:0]      b_ref_x_q, b_ref_y_q, b_fx_q, b_fy_q;
  logic                     b_axis_q;

  // Stage C: result register.
  logic                     c_vld_q;
  logic [DUTY_OUT_W-1:0]    c_duty_x_q, c_duty_y_q;
  logic                     c_clip_x_q, c_clip_y_q, c_axis_q;

  logic c_free, b_free, a_free, b_move, a_move, in_acc, cfg_acc;

  // Handshake: each stage advances when the one after it has room.
  assign c_free = !c_vld_q || result_o.ready;
  assign b_move = b_vld_q && c_free;
  assign b_free = !b_vld_q || c_free;
  assign a_move = a_vld_q && b_free;
  assign a_free = !a_vld_q || b_free;
  assign in_acc = sample_i.valid && a_free;

  assign sample_i.ready = a_free;
  assign cfg_i.ready    = 1'b1;
  assign cfg_acc        = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_x_q <= GAIN_P_X_RST;
      gain_d_x_q <= GAIN_D_X_RST;
      gain_p_y_q <= GAIN_P_Y_RST;
      gain_d_y_q <= GAIN_D_Y_RST;
      centre_x_q <= CENTRE_DUTY_X_RST;
      centre_y_q <= CENTRE_DUTY_Y_RST;
      duty_min_q <= DUTY_MIN_RST;
      duty_max_q <= DUTY_MAX_RST;
    end else if (cfg_acc) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_GAIN_P_X:      gain_p_x_q <= cfg_i.data;
        REG_GAIN_D_X:      gain_d_x_q <= cfg_i.data;
        REG_GAIN_P_Y:      gain_p_y_q <= cfg_i.data;
        REG_GAIN_D_Y:      gain_d_y_q <= cfg_i.data;
        REG_CENTRE_DUTY_X: centre_x_q <= cfg_i.data;
        REG_CENTRE_DUTY_Y: centre_y_q <= cfg_i.data;
        REG_DUTY_MIN:      duty_min_q <= cfg_i.data;
        REG_DUTY_MAX:      duty_max_q <= cfg_i.data;
      endcase
    end
  end

  // Lowpass on the selected axis: rounded half up, Q0.16 weights.
  logic [POS_BITS-1:0]   filt_old, filt_new, sample_pos;
  logic [FILT_ACC_W-1:0] filt_acc;

  always_comb begin
    filt_old   = axis_sel_q ? filt_y_q : filt_x_q;
    sample_pos = {a_sample_q, {FRAC_BITS{1'b0}}};
    filt_acc   = FILT_ACC_W'(IN_WEIGHT_Q16) * FILT_ACC_W'(sample_pos)
               + FILT_ACC_W'(FB_WEIGHT_Q16) * FILT_ACC_W'(filt_old)
               + FILT_ACC_W'(FILT_ROUND);
    filt_new   = filt_acc[COEF_FRAC +: POS_BITS];
  end

  // PD step for both axes.
  pd_gains_t               gains_x, gains_y;
  duty_lim_t               lim;
  logic signed [ERR_W-1:0] err_x, err_y;
  pd_result_t              res_x, res_y;

  assign gains_x = '{kp: gain_p_x_q, kd: gain_d_x_q, centre: centre_x_q};
  assign gains_y = '{kp: gain_p_y_q, kd: gain_d_y_q, centre: centre_y_q};
  assign lim     = '{lo: duty_min_q, hi: duty_max_q};

  tafps_pd_axis u_pd_x (
    .ref_i      (b_ref_x_q),
    .filt_i     (b_fx_q),
    .prev_err_i (prev_err_x_q),
    .gains_i    (gains_x),
    .lim_i      (lim),
    .err_o      (err_x),
    .res_o      (res_x)
  );

  tafps_pd_axis u_pd_y (
    .ref_i      (b_ref_y_q),
    .filt_i     (b_fy_q),
    .prev_err_i (prev_err_y_q),
    .gains_i    (gains_y),
    .lim_i      (lim),
    .err_o      (err_y),
    .res_o      (res_y)
  );

  // Control: valid bits and loop state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q      <= 1'b0;
      b_vld_q      <= 1'b0;
      c_vld_q      <= 1'b0;
      axis_sel_q   <= 1'b0;
      filt_x_q     <= '0;
      filt_y_q     <= '0;
      prev_err_x_q <= '0;
      prev_err_y_q <= '0;
    end else begin
      if (a_free) a_vld_q <= sample_i.valid;
      if (b_free) b_vld_q <= a_vld_q;
      if (c_free) c_vld_q <= b_vld_q;
      // Commit the filter update and flip the axis as the beat leaves stage A.
      if (a_move) begin
        axis_sel_q <= ~axis_sel_q;
        if (axis_sel_q) filt_y_q <= filt_new;
        else            filt_x_q <= filt_new;
      end
      // Commit the errors as the beat leaves stage B.
      if (b_move) begin
        prev_err_x_q <= err_x;
        prev_err_y_q <= err_y;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_sample_q <= sample_i.adc_sample;
      a_ref_x_q  <= sample_i.ref_x;
      a_ref_y_q  <= sample_i.ref_y;
    end
    if (a_move) begin
      b_ref_x_q <= a_ref_x_q;
      b_ref_y_q <= a_ref_y_q;
      b_fx_q    <= axis_sel_q ? filt_x_q : filt_new;
      b_fy_q    <= axis_sel_q ? filt_new : filt_y_q;
      b_axis_q  <= axis_sel_q;
    end
    if (b_move) begin
      c_duty_x_q <= res_x.duty;
      c_duty_y_q <= res_y.duty;
      c_clip_x_q <= res_x.clip;
      c_clip_y_q <= res_y.clip;
      c_axis_q   <= b_axis_q;
    end
  end

  assign result_o.valid        = c_vld_q;
  assign result_o.duty_x       = c_duty_x_q;
  assign result_o.duty_y       = c_duty_y_q;
  assign result_o.clipped_x    = c_clip_x_q;
  assign result_o.clipped_y    = c_clip_y_q;
  assign result_o.sampled_axis = c_axis_q;

  `TAFPS_ASSERT(sel_toggles, a_move |=> axis_sel_q != $past(axis_sel_q))
  `TAFPS_ASSERT(filt_holds, !a_move |=> $stable(filt_x_q) && $stable(filt_y_q))
  `TAFPS_ASSERT(err_holds, !b_move |=> $stable(prev_err_x_q) && $stable(prev_err_y_q))
  `TAFPS_ASSERT_IMPL(stall_only_full, !sample_i.ready, a_vld_q && b_vld_q && c_vld_q && !result_o.ready)

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import tafps_pkg::*;

  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_PERIODS  = 166;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_LEN   = 200;
  localparam int MAX_REPORTS    = 10;

  // One control period as it goes into the block.
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] adc;
    logic [POS_BITS-1:0]    ref_x;
    logic [POS_BITS-1:0]    ref_y;
  } period_t;

  // One servo command as it comes out.
  typedef struct packed {
    logic [DUTY_OUT_W-1:0] duty_x;
    logic [DUTY_OUT_W-1:0] duty_y;
    logic                  clip_x;
    logic                  clip_y;
    logic                  axis;
  } servo_cmd_t;

  logic clk_i;
  logic rst_ni;

  tafps_in_if  sample_if ();
  tafps_out_if result_if ();
  tafps_cfg_if cfg_if ();

  two_axis_filtered_pd_servo_top u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  // ---------------------------------------------------------------------------
  // Servo predictor: own copy of the registers, the lowpass state and the
  // previous errors. It advances once per accepted period beat.
  // ---------------------------------------------------------------------------
  logic [15:0]         reg_shadow [8];
  logic                axis_next;
  logic [POS_BITS-1:0] pos_x;
  logic [POS_BITS-1:0] pos_y;
  longint              last_err_x;
  longint              last_err_y;

  // First-order lowpass, Q0.16 weights, rounded half up.
  function automatic logic [POS_BITS-1:0] smooth(input logic [POS_BITS-1:0] pos,
                                                 input logic [SAMPLE_BITS-1:0] adc);
    longint acc;
    acc = longint'(IN_WEIGHT_Q16) * (longint'(adc) <<< FRAC_BITS)
        + longint'(FB_WEIGHT_Q16) * longint'(pos) + longint'(FILT_ROUND);
    return acc[COEF_FRAC +: POS_BITS];
  endfunction

  // PD step on one axis; returns {clip, duty}. Duty math is exact and signed,
  // capped at the ceiling first and then raised to the floor.
  function automatic logic [DUTY_OUT_W:0] steer(input logic [POS_BITS-1:0] target,
                                                input logic [POS_BITS-1:0] pos,
                                                inout longint last_err,
                                                input logic [15:0] kp,
                                                input logic [15:0] kd,
                                                input logic [15:0] centre);
    longint err;
    longint acc;
    longint mag;
    longint duty;
    logic   clip;
    err      = longint'(target) - longint'(pos);
    acc      = longint'(kp) * err + longint'(kd) * (err - last_err);
    last_err = err;
    // truncate toward zero: shift the magnitude, then restore the sign
    mag  = (acc < 0) ? -acc : acc;
    mag  = mag >>> PD_SHIFT;
    duty = longint'(centre) - ((acc < 0) ? -mag : mag);
    clip = 1'b0;
    if (duty > longint'(reg_shadow[REG_DUTY_MAX])) begin
      duty = longint'(reg_shadow[REG_DUTY_MAX]);
      clip = 1'b1;
    end
    if (duty < longint'(reg_shadow[REG_DUTY_MIN])) begin
      duty = longint'(reg_shadow[REG_DUTY_MIN]);
      clip = 1'b1;
    end
    return {clip, duty[DUTY_OUT_W-1:0]};
  endfunction

  // Whole control period: filter the selected axis, toggle the selector,
  // then run PD on both axes (the unsampled one on its last filtered value).
  function automatic servo_cmd_t servo_period(input period_t p);
    servo_cmd_t            c;
    logic [DUTY_OUT_W:0]   sx;
    logic [DUTY_OUT_W:0]   sy;
    c.axis = axis_next;
    if (!axis_next) begin
      pos_x = smooth(pos_x, p.adc);
    end else begin
      pos_y = smooth(pos_y, p.adc);
    end
    axis_next = ~axis_next;
    sx = steer(p.ref_x, pos_x, last_err_x, reg_shadow[REG_GAIN_P_X],
               reg_shadow[REG_GAIN_D_X], reg_shadow[REG_CENTRE_DUTY_X]);
    sy = steer(p.ref_y, pos_y, last_err_y, reg_shadow[REG_GAIN_P_Y],
               reg_shadow[REG_GAIN_D_Y], reg_shadow[REG_CENTRE_DUTY_Y]);
    c.duty_x = sx[DUTY_OUT_W-1:0];
    c.clip_x = sx[DUTY_OUT_W];
    c.duty_y = sy[DUTY_OUT_W-1:0];
    c.clip_y = sy[DUTY_OUT_W];
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Bookkeeping shared by the processes below.
  // ---------------------------------------------------------------------------
  period_t    period_q [$];     // periods waiting to be driven
  servo_cmd_t servo_cmd_q [$];  // predicted commands, oldest first
  int         n_offered;        // period beats put on the bus
  int         n_taken;          // period beats accepted
  int         n_bad;
  int         idle_cycles;
  bit         hold_off_req;
  bit         hold_off_done;
  int         walk;             // slowly moving plate position for stimulus

  // Gap length for either side: mostly none or short, now and then long,
  // with calm stretches of back-to-back beats in between.
  function automatic int next_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm = $urandom_range(16, 64);
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  function automatic void report_bad(input string what, input servo_cmd_t want,
                                     input servo_cmd_t got);
    n_bad++;
    if (n_bad <= MAX_REPORTS) begin
      $display("[%0t] %s: expected duty_x=%0d duty_y=%0d clip_x=%0b clip_y=%0b axis=%0b",
               $time, what, want.duty_x, want.duty_y, want.clip_x, want.clip_y, want.axis);
      $display("           actual   duty_x=%0d duty_y=%0d clip_x=%0b clip_y=%0b axis=%0b",
               got.duty_x, got.duty_y, got.clip_x, got.clip_y, got.axis);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Period driver: present one beat at a time from period_q, hold it until
  // the block takes it, then idle for a random gap. All updates at negedge.
  // ---------------------------------------------------------------------------
  int tx_gap;
  int tx_calm;

  always @(negedge clk_i) begin
    period_t p;
    // only touch the bus once the current beat has gone through
    if (rst_ni && n_offered == n_taken) begin
      if (tx_gap > 0) begin
        tx_gap--;
        sample_if.valid <= 1'b0;
      end else if (period_q.size() > 0) begin
        p = period_q.pop_front();
        sample_if.valid      <= 1'b1;
        sample_if.adc_sample <= p.adc;
        sample_if.ref_x      <= p.ref_x;
        sample_if.ref_y      <= p.ref_y;
        n_offered++;
        tx_gap = next_gap(tx_calm);
      end else begin
        sample_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls, plus one long hold-off on request so the
  // pipeline backs up and the block has to drop its input ready.
  // ---------------------------------------------------------------------------
  int rx_gap;
  int rx_calm;
  int rx_hold;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off_req && !hold_off_done) begin
        rx_hold       = HOLD_OFF_LEN;
        hold_off_done = 1'b1;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        result_if.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
        rx_gap = next_gap(rx_calm);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each accepted period beat, check each accepted result
  // beat against the oldest prediction, and run the stall watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    period_t    p;
    servo_cmd_t got;
    servo_cmd_t want;
    bit         moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (sample_if.valid && sample_if.ready) begin
        p.adc   = sample_if.adc_sample;
        p.ref_x = sample_if.ref_x;
        p.ref_y = sample_if.ref_y;
        servo_cmd_q.push_back(servo_period(p));
        n_taken++;
        moved = 1'b1;
      end
      if (result_if.valid && result_if.ready) begin
        moved      = 1'b1;
        got.duty_x = result_if.duty_x;
        got.duty_y = result_if.duty_y;
        got.clip_x = result_if.clipped_x;
        got.clip_y = result_if.clipped_y;
        got.axis   = result_if.sampled_axis;
        if (servo_cmd_q.size() == 0) begin
          report_bad("result with nothing expected", '0, got);
        end else begin
          want = servo_cmd_q.pop_front();
          if (got.duty_x !== want.duty_x || got.duty_y !== want.duty_y ||
              got.clip_x !== want.clip_x || got.clip_y !== want.clip_y ||
              got.axis !== want.axis) begin
            report_bad("mismatch", want, got);
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) moved = 1'b1;
    end
    // nothing accepted on any channel for too long: give up
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no beat accepted for %0d cycles", $time, idle_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    reg_shadow[idx] = val;
  endtask

  // Write all eight registers back to back, in index order.
  task automatic load_config(input logic [15:0] vals [8]);
    for (int i = 0; i < 8; i++) write_reg(cfg_reg_e'(i), vals[i]);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until every period has been taken and answered; the pipeline is
  // then empty, but let the clock run on anyway.
  task automatic drain();
    wait (period_q.size() == 0 && n_offered == n_taken && servo_cmd_q.size() == 0);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic void push_period(input int adc, input int rx, input int ry);
    period_t p;
    p.adc   = adc[SAMPLE_BITS-1:0];
    p.ref_x = rx[POS_BITS-1:0];
    p.ref_y = ry[POS_BITS-1:0];
    period_q.push_back(p);
  endfunction

  // Reference a little off the given position, clamped to the field.
  function automatic logic [POS_BITS-1:0] near(input int pos);
    int v;
    v = pos + int'($urandom_range(0, 4095)) - 2048;
    if (v < 0) v = 0;
    if (v > (1 << POS_BITS) - 1) v = (1 << POS_BITS) - 1;
    return v[POS_BITS-1:0];
  endfunction

  // Mostly a ball rolling slowly with references near it; the rest raw noise.
  function automatic period_t make_period();
    period_t p;
    int      step;
    if ($urandom_range(0, 3) == 0) begin
      p.adc   = SAMPLE_BITS'($urandom);
      p.ref_x = POS_BITS'($urandom);
      p.ref_y = POS_BITS'($urandom);
    end else begin
      if ($urandom_range(0, 49) == 0) walk = $urandom_range(0, (1 << SAMPLE_BITS) - 1);
      step = int'($urandom_range(0, 24)) - 12;
      walk = walk + step;
      if (walk < 0) walk = 0;
      if (walk > (1 << SAMPLE_BITS) - 1) walk = (1 << SAMPLE_BITS) - 1;
      p.adc   = walk[SAMPLE_BITS-1:0];
      p.ref_x = near(walk <<< FRAC_BITS);
      p.ref_y = near(walk <<< FRAC_BITS);
    end
    return p;
  endfunction

  // Either a tame tuning around the plate's level duty, or anything at all.
  function automatic void pick_config(output logic [15:0] vals [8]);
    if ($urandom_range(0, 9) < 6) begin
      vals[REG_GAIN_P_X]      = 16'($urandom_range(0, 255));
      vals[REG_GAIN_D_X]      = 16'($urandom_range(0, 2047));
      vals[REG_GAIN_P_Y]      = 16'($urandom_range(0, 255));
      vals[REG_GAIN_D_Y]      = 16'($urandom_range(0, 2047));
      vals[REG_CENTRE_DUTY_X] = 16'($urandom_range(3400, 4000));
      vals[REG_CENTRE_DUTY_Y] = 16'($urandom_range(3400, 4000));
      vals[REG_DUTY_MIN]      = 16'($urandom_range(3300, 3700));
      vals[REG_DUTY_MAX]      = 16'($urandom_range(3700, 4100));
    end else begin
      for (int i = 0; i < 8; i++) vals[i] = 16'($urandom);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  localparam int POS_MAX = (1 << POS_BITS) - 1;
  localparam int ADC_MAX = (1 << SAMPLE_BITS) - 1;

  initial begin
    logic [15:0] regs [8];
    int          base;

    // drive every input from time zero
    rst_ni               = 1'b0;
    sample_if.valid      = 1'b0;
    sample_if.adc_sample = '0;
    sample_if.ref_x      = '0;
    sample_if.ref_y      = '0;
    result_if.ready      = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = REG_GAIN_P_X;
    cfg_if.data          = '0;

    reg_shadow[REG_GAIN_P_X]      = GAIN_P_X_RST;
    reg_shadow[REG_GAIN_D_X]      = GAIN_D_X_RST;
    reg_shadow[REG_GAIN_P_Y]      = GAIN_P_Y_RST;
    reg_shadow[REG_GAIN_D_Y]      = GAIN_D_Y_RST;
    reg_shadow[REG_CENTRE_DUTY_X] = CENTRE_DUTY_X_RST;
    reg_shadow[REG_CENTRE_DUTY_Y] = CENTRE_DUTY_Y_RST;
    reg_shadow[REG_DUTY_MIN]      = DUTY_MIN_RST;
    reg_shadow[REG_DUTY_MAX]      = DUTY_MAX_RST;
    axis_next  = 1'b0;
    pos_x      = '0;
    pos_y      = '0;
    last_err_x = 0;
    last_err_y = 0;
    walk       = 512;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, reset tuning: field extremes, both axes alternating, so each
    // axis also runs on its stale filtered value every other period.
    push_period(0, 0, 0);
    push_period(ADC_MAX, POS_MAX, POS_MAX);
    push_period(ADC_MAX, POS_MAX, POS_MAX);
    push_period(0, 0, POS_MAX);
    push_period(0, POS_MAX, 0);
    push_period(512, 1 << (POS_BITS - 1), 1 << (POS_BITS - 1));
    push_period(ADC_MAX, 0, 0);
    push_period(0, 0, 0);
    drain();

    // Full-scale gains and centre on x, zero P gain and centre on y, widest limits: huge PD terms of both signs.
    // Order: gain_p_x, gain_d_x, gain_p_y, gain_d_y, centre_x, centre_y, min, max
    regs = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF};
    load_config(regs);
    push_period(ADC_MAX, POS_MAX, 0);
    push_period(0, 0, POS_MAX);
    push_period(ADC_MAX, POS_MAX, POS_MAX);
    push_period(0, 0, 0);
    push_period(ADC_MAX, POS_MAX, 0);
    push_period(0, 0, POS_MAX);
    drain();

    // Floor above ceiling: every duty lands on the floor, flagged as clipped.
    regs = '{16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'd4000, 16'd3000};
    load_config(regs);
    push_period(ADC_MAX, POS_MAX, 0);
    push_period(0, 0, POS_MAX);
    push_period(ADC_MAX, 0, POS_MAX);
    push_period(0, POS_MAX, 0);
    drain();

    // Zero gains: duty is the centre, which sits exactly on each limit.
    regs = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
    load_config(regs);
    push_period(ADC_MAX, POS_MAX, POS_MAX);
    push_period(0, 0, 0);
    push_period(ADC_MAX, 0, POS_MAX);
    push_period(0, POS_MAX, 0);
    drain();

    // Random phases, each under its own tuning. The first one also gets the
    // long receiver hold-off while the driver keeps offering periods.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == RANDOM_PHASES - 1) begin
        // back to the stock tuning for the last phase
        regs = '{GAIN_P_X_RST, GAIN_D_X_RST, GAIN_P_Y_RST, GAIN_D_Y_RST,
                 CENTRE_DUTY_X_RST, CENTRE_DUTY_Y_RST, DUTY_MIN_RST, DUTY_MAX_RST};
      end else begin
        pick_config(regs);
      end
      load_config(regs);
      base = n_taken;
      for (int i = 0; i < PHASE_PERIODS; i++) period_q.push_back(make_period());
      if (ph == 0) begin
        wait (n_taken >= base + 40);
        hold_off_req = 1'b1;
      end
      drain();
    end

    // let any stray beat show up before the verdict
    repeat (20) @(posedge clk_i);
    if (n_bad == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
